[src/stks_pkg.sv]
// Shared types, constants and the ranking function of the top-k selector.
`timescale 1ns / 1ps
package stks_pkg;

    localparam int MAX_K   = 64;
    localparam int FILL_W  = $clog2(MAX_K + 1);
    localparam int K_W     = 7;
    localparam int SCORE_W = 16;
    localparam int ID_W    = 32;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_cmd_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    // True when entry a ranks strictly above entry b: higher score, then higher id
    function automatic logic ranks_above(entry_t a, entry_t b);
        logic res;
        if (a.score != b.score)
            res = (a.score > b.score);
        else
            res = (a.id > b.id);
        return res;
    endfunction

endpackage

[src/stks_cell.sv]
// One cell of the sorted insertion chain: holds one entry, compares and shifts.
`timescale 1ns / 1ps
module stks_cell
    import stks_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      valid,
    input  entry_t    up_entry,
    input  logic      up_ins,
    input  entry_t    down_entry,
    output entry_t    entry,
    output logic      ins,
    output logic      gt
);

    entry_t entry_reg;
    entry_t entry_next;

    // Flag where the new word belongs: empty slot, or it outranks the held one
    always_comb
    begin
        ins = !valid || ranks_above(cmd.new_entry, entry_reg);
        gt  = valid && (cmd.new_entry.score > entry_reg.score);
    end

    // Take from the upper neighbor, the new word, or the lower neighbor
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CELL_INSERT:
            begin
                if (up_ins)
                    entry_next = up_entry;
                else if (ins)
                    entry_next = cmd.new_entry;
            end
            CELL_SHIFT:
                entry_next = down_entry;
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[src/stks_ctrl.sv]
// Control of the top-k selector: handshakes, fill count, id counter, drain.
`timescale 1ns / 1ps
module stks_ctrl
    import stks_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [K_W-1:0]     cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SCORE_W-1:0] score,
    input  logic               last_doc,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               final_res,
    input  logic               any_gt,
    output cell_cmd_t          cmd,
    output logic [FILL_W-1:0]  fill
);

    state_t             state_reg;
    state_t             state_next;
    logic [K_W-1:0]     top_k_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [ID_W-1:0]    next_id_reg;
    logic [ID_W-1:0]    next_id_next;
    logic [FILL_W-1:0]  k_eff;
    logic               full;
    logic               in_acc;
    logic               out_acc;

    // Clamp the configured depth into 1..MAX_K
    always_comb
    begin
        if (top_k_reg > K_W'(MAX_K))
            k_eff = FILL_W'(MAX_K);
        else if (top_k_reg == '0)
            k_eff = FILL_W'(1);
        else
            k_eff = FILL_W'(top_k_reg);
    end

    assign full    = (fill_reg >= k_eff);
    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Next state, fill count and id counter
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        next_id_next = next_id_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc)
                begin
                    next_id_next = next_id_reg + ID_W'(1);
                    if (!full)
                        fill_next = fill_reg + FILL_W'(1);
                    if (last_doc)
                    begin
                        state_next   = ST_DRAIN;
                        next_id_next = '0;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_acc)
                begin
                    fill_next = fill_reg - FILL_W'(1);
                    if (fill_reg == FILL_W'(1))
                        state_next = ST_COLLECT;
                end
            end
            default:
                state_next = ST_COLLECT;
        endcase
    end

    // Outputs: handshakes and the command broadcast to the chain
    always_comb
    begin
        in_ready          = 1'b0;
        out_valid         = 1'b0;
        cmd.op            = CELL_HOLD;
        cmd.new_entry.score = score;
        cmd.new_entry.id  = next_id_reg;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_valid && (!full || any_gt))
                    cmd.op = CELL_INSERT;
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    cmd.op = CELL_SHIFT;
            end
            default:
                cmd.op = CELL_HOLD;
        endcase
    end

    assign final_res = (fill_reg == FILL_W'(1));
    assign fill      = fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            top_k_reg   <= K_W'(10);
            fill_reg    <= '0;
            next_id_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            next_id_reg <= next_id_next;
            if (cfg_we)
                top_k_reg <= cfg_wdata;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_K))
        else $error("fill count above store depth");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> fill_reg != '0)
        else $error("drain with empty store");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && final_res |=> state_reg == ST_COLLECT && fill_reg == '0
            && next_id_reg == '0)
        else $error("store not cleared after final word");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && last_doc |=> state_reg == ST_DRAIN)
        else $error("last document did not start drain");
`endif

endmodule

[src/streaming_top_k_selector.sv]
// Top level of the streaming top-k selector: control plus a sorted chain of cells.
`timescale 1ns / 1ps
// Takes one score word per cycle (in_ready stays high while collecting) and
// numbers documents from 0 in arrival order. A chain of MAX_K cells keeps the
// held entries sorted by score, then id, highest first; every cell compares
// the incoming word against its own entry in the same cycle, so insertion
// does not slow as the store fills. After a word marked last_doc the block
// stops taking input and drains the held entries from the head of the chain,
// one result word per cycle while out_ready is high, marking the last with
// final_res. The store and id counter are clear again when the final word is
// taken. top_k must be written through cfg_we/cfg_wdata only while idle; the
// block itself does not enforce this.
module streaming_top_k_selector
    import stks_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [K_W-1:0]     cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SCORE_W-1:0] score,
    input  logic               last_doc,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ID_W-1:0]    doc_id,
    output logic [SCORE_W-1:0] sel_score,
    output logic               final_res
);

    cell_cmd_t          cmd;
    logic [FILL_W-1:0]  fill;
    entry_t             entries [MAX_K];
    logic [MAX_K-1:0]   ins_vec;
    logic [MAX_K-1:0]   gt_vec;
    logic               any_gt;

    // Any held score below the new one: the new word displaces the lowest
    assign any_gt = |gt_vec;

    stks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .score     (score),
        .last_doc  (last_doc),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .final_res (final_res),
        .any_gt    (any_gt),
        .cmd       (cmd),
        .fill      (fill)
    );

    // Build the chain; the head cell drives the result word
    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        entry_t up_entry;
        entry_t down_entry;
        logic   up_ins;
        logic   valid;

        assign valid = (fill > FILL_W'(i));

        if (i == 0)
        begin : g_head
            assign up_entry = entries[i];
            assign up_ins   = 1'b0;
        end
        else
        begin : g_body
            assign up_entry = entries[i-1];
            assign up_ins   = ins_vec[i-1];
        end

        if (i == MAX_K - 1)
        begin : g_tail
            assign down_entry = entries[i];
        end
        else
        begin : g_mid
            assign down_entry = entries[i+1];
        end

        stks_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .valid      (valid),
            .up_entry   (up_entry),
            .up_ins     (up_ins),
            .down_entry (down_entry),
            .entry      (entries[i]),
            .ins        (ins_vec[i]),
            .gt         (gt_vec[i])
        );
    end

    assign doc_id    = entries[0].id;
    assign sel_score = entries[0].score;

endmodule

[bench/stks_ranking_checker.sv]
// Checker for the streaming top-k selector: predicts the ranked result words and compares them.
`timescale 1ns / 1ps
module stks_ranking_checker
    import stks_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [K_W-1:0]     cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [SCORE_W-1:0] score,
    input  logic               last_doc,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [ID_W-1:0]    doc_id,
    input  logic [SCORE_W-1:0] sel_score,
    input  logic               final_res,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);

    localparam logic [K_W-1:0] RESET_TOP_K = 7'd10;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic               last;
    } ranked_doc_t;

    // Ranked documents still owed by the block, oldest first
    ranked_doc_t        ranked_docs_due[$];

    // Predicted store contents, in slot order
    logic [SCORE_W-1:0] kept_score[MAX_K];
    logic [ID_W-1:0]    kept_id[MAX_K];
    int                 kept_count;
    logic [ID_W-1:0]    doc_ctr;
    logic [K_W-1:0]     keep_k;

    // Map the register value onto the number of documents actually kept
    function automatic int clamped_k(logic [K_W-1:0] k);
        if (k == '0)
            return 1;
        if (k > MAX_K)
            return MAX_K;
        return int'(k);
    endfunction

    // Higher score wins; on equal scores the higher id wins
    function automatic bit outranks(logic [SCORE_W-1:0] sa, logic [ID_W-1:0] ia,
                                    logic [SCORE_W-1:0] sb, logic [ID_W-1:0] ib);
        if (sa != sb)
            return sa > sb;
        return ia > ib;
    endfunction

    // Enter one document: fill while room is left, else replace the weakest entry if the new score is higher
    task automatic admit_doc(logic [SCORE_W-1:0] s, logic [ID_W-1:0] id);
        int lo;
        lo = 0;
        if (kept_count < clamped_k(keep_k))
        begin
            kept_score[kept_count] = s;
            kept_id[kept_count]    = id;
            kept_count++;
        end
        else
        begin
            for (int i = 1; i < kept_count; i++)
            begin
                if (outranks(kept_score[lo], kept_id[lo], kept_score[i], kept_id[i]))
                    lo = i;
            end
            if (s > kept_score[lo])
            begin
                kept_score[lo] = s;
                kept_id[lo]    = id;
            end
        end
    endtask

    // Sort the store best first, queue it as expected words, then clear it
    task automatic rank_and_queue();
        ranked_doc_t order[MAX_K];
        ranked_doc_t cur;
        int          j;
        for (int i = 0; i < kept_count; i++)
        begin
            cur.id    = kept_id[i];
            cur.score = kept_score[i];
            cur.last  = 1'b0;
            j = i;
            while (j > 0 && outranks(cur.score, cur.id, order[j-1].score, order[j-1].id))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        for (int i = 0; i < kept_count; i++)
        begin
            order[i].last = (i == kept_count - 1);
            ranked_docs_due.push_back(order[i]);
        end
        kept_count = 0;
        doc_ctr    = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ranked_doc_t want;
        if (!rst_n)
        begin
            ranked_docs_due.delete();
            kept_count = 0;
            doc_ctr    = '0;
            keep_k     = RESET_TOP_K;
            fail_count = 0;
            checked    = 0;
        end
        else
        begin
            // Compare a result word taken this cycle against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (ranked_docs_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result word id %0d score %0d final %0b",
                             $time, doc_id, sel_score, final_res);
                end
                else
                begin
                    want = ranked_docs_due.pop_front();
                    checked++;
                    if (doc_id !== want.id)
                    begin
                        fail_count++;
                        $display("%0t: doc_id mismatch, expected %0d, actual %0d",
                                 $time, want.id, doc_id);
                    end
                    if (sel_score !== want.score)
                    begin
                        fail_count++;
                        $display("%0t: sel_score mismatch, expected %0d, actual %0d",
                                 $time, want.score, sel_score);
                    end
                    if (final_res !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: final_res mismatch, expected %0b, actual %0b",
                                 $time, want.last, final_res);
                    end
                end
            end
            // Advance the predicted store on an accepted score word
            if (in_valid && in_ready)
            begin
                admit_doc(score, doc_ctr);
                doc_ctr = doc_ctr + ID_W'(1);
                if (last_doc)
                    rank_and_queue();
            end
            // Track register writes
            if (cfg_we)
                keep_k = cfg_wdata;
        end
        pending = ranked_docs_due.size();
    end

endmodule

[bench/tb_streaming_top_k_selector.sv]
// Testbench top for the streaming top-k selector: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_streaming_top_k_selector
    import stks_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 4;
    localparam int RANDOM_WORDS = 200;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [K_W-1:0]     cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [SCORE_W-1:0] score;
    logic               last_doc;
    logic               out_valid;
    logic               out_ready;
    logic [ID_W-1:0]    doc_id;
    logic [SCORE_W-1:0] sel_score;
    logic               final_res;

    int fail_count;
    int pending;
    int checked;
    int words_sent;
    int queries_sent;
    int cycles;
    bit long_hold_req;

    logic [SCORE_W-1:0] script[$];

    streaming_top_k_selector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .score     (score),
        .last_doc  (last_doc),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .doc_id    (doc_id),
        .sel_score (sel_score),
        .final_res (final_res)
    );

    stks_ranking_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .score      (score),
        .last_doc   (last_doc),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .doc_id     (doc_id),
        .sel_score  (sel_score),
        .final_res  (final_res),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d result words still due", cycles, pending);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: free stretches, short and long stalls, one forced long hold
    initial
    begin
        int stall_left;
        int free_left;
        int r;
        stall_left = 0;
        free_left  = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
                free_left     = 0;
            end
            if (stall_left == 0 && free_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    free_left = $urandom_range(1, 30);
                else if (r < 90)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(8, 40);
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                free_left--;
            end
        end
    end

    // Gap before the next score word: mostly none or short, a few long
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Scores: full range, heavy ties, a narrow band, or values at the edges
    function automatic logic [SCORE_W-1:0] pick_score(int style);
        case (style)
            1: return SCORE_W'($urandom_range(0, 7));
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return 16'h0000;
                    1: return 16'h0001;
                    2: return 16'h7fff;
                    3: return 16'h8000;
                    4: return 16'hfffe;
                    default: return 16'hffff;
                endcase
            end
            3: return SCORE_W'($urandom_range(1000, 1015));
            default: return SCORE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Cycle through the register extremes with random settings in between
    function automatic logic [K_W-1:0] pick_top_k(int n);
        case (n % 5)
            0: return 7'd64;
            1: return 7'd1;
            2: return $urandom_range(0, 1) ? 7'd0 : 7'd127;
            default: return K_W'($urandom_range(0, 127));
        endcase
    endfunction

    // Offer one score word and hold it until it is taken
    task automatic send_word(logic [SCORE_W-1:0] s, logic is_last, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        score    <= s;
        last_doc <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // Drop valid and wait until every owed result word is out and the chain is quiet
    task automatic drain_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_top_k(logic [K_W-1:0] k);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Send the scripted scores as one query, last word marked
    task automatic play_script();
        foreach (script[i])
            send_word(script[i], i == script.size() - 1, pick_gap(1'b0));
        queries_sent++;
    endtask

    // Send a query of random scores, optionally rewriting top_k partway through
    task automatic random_query(int len, int style, bit calm, int split);
        for (int i = 0; i < len; i++)
        begin
            if (split != 0 && i == split)
            begin
                drain_wait();
                write_top_k(pick_top_k($urandom_range(0, 4)));
            end
            send_word(pick_score(style), i == len - 1, pick_gap(calm));
        end
        queries_sent++;
    endtask

    initial
    begin
        int len;
        int split;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        score         = '0;
        last_doc      = 1'b0;
        long_hold_req = 1'b0;
        words_sent    = 0;
        queries_sent  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default top_k: extremes, equal scores and evictions with ties
        script = '{16'h0000, 16'hffff, 16'd5, 16'd5, 16'd5, 16'haaaa, 16'h5555,
                   16'hffff, 16'h0000, 16'd1, 16'd1, 16'd2, 16'd3, 16'h8000};
        play_script();
        drain_wait();

        // top_k of zero keeps one; an equal score must not displace it
        write_top_k(7'd0);
        script = '{16'd7, 16'd7, 16'd9};
        play_script();
        drain_wait();

        // Oversized top_k, single-document query
        write_top_k(7'd127);
        script = '{16'hffff};
        play_script();
        drain_wait();

        write_top_k(7'd1);
        script = '{16'd3, 16'd2, 16'd3, 16'd4};
        play_script();
        drain_wait();

        // Hold the result side long while queries go in back to back
        write_top_k(7'd64);
        long_hold_req = 1'b1;
        random_query(70, 0, 1'b1, 0);
        random_query(12, 1, 1'b1, 0);
        random_query(20, 2, 1'b0, 0);
        drain_wait();

        // Random queries; most start from a fresh top_k, some follow back to back
        while (words_sent < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                drain_wait();
                write_top_k(pick_top_k(queries_sent));
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            split = 0;
            if (len > 1 && $urandom_range(0, 5) == 0)
                split = $urandom_range(1, len - 1);
            random_query(len, $urandom_range(0, 3), $urandom_range(0, 4) == 0, split);
        end

        drain_wait();
        repeat (20) @(posedge clk);
        $display("Sent %0d score words in %0d queries, checked %0d ranked result words.",
                 words_sent, queries_sent, checked);
        $display("Covered top_k 0, 1, 64 and 127, mid-query rewrites and a long output stall.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
